// ===== design/orbc_pkg.sv =====
package orbc_pkg;

    localparam int WORD_W    = 32;
    localparam int OP_W      = 2;
    localparam int CAP_W     = 6;
    localparam int OCC_W     = 6;
    localparam int OVW_W     = 16;
    localparam int CKS_W     = 8;
    localparam int DEPTH_DEF = 32;
    localparam int QDEPTH    = 2;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 6'd32;
    localparam logic [WORD_W-1:0] EMPTY_WORD = 32'hABCD_EF01;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_POP   = 2'd1,
        OP_DUMP  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] data;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_POP_WAIT = 2'd1,
        ST_DUMP     = 2'd2
    } bk_state_t;

    // Sum of the four bytes of a word, modulo 256.
    function automatic logic [CKS_W-1:0] byte_sum(input logic [WORD_W-1:0] w);
        logic [CKS_W-1:0] s;
        s = w[7:0] + w[15:8] + w[23:16] + w[31:24];
        return s;
    endfunction

endpackage

// ===== design/orbc_ram.sv =====
module orbc_ram #(
    parameter int WIDTH = orbc_pkg::WORD_W,
    parameter int DEPTH = orbc_pkg::DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/orbc_front.sv =====
module orbc_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [orbc_pkg::OP_W-1:0]       op,
    input  logic [orbc_pkg::WORD_W-1:0]     data_in,
    output logic                            cmd_valid,
    output orbc_pkg::cmd_t                  cmd,
    input  logic                            cmd_take
);

    import orbc_pkg::*;

    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    cmd_t           q_reg [QDEPTH];
    logic [QAW-1:0] head_reg, head_next;
    logic [QAW-1:0] tail_reg, tail_next;
    logic [QCW-1:0] cnt_reg, cnt_next;
    cmd_t           cmd_in;
    logic           push;

    // Decode the operation; the data word only matters for a put.
    always_comb
    begin
        cmd_in.op   = op_t'(op);
        cmd_in.data = (op_t'(op) == OP_PUT) ? data_in : '0;
    end

    assign in_stall  = (cnt_reg == QCW'(QDEPTH));
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[head_reg];

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            tail_next = (tail_reg == QAW'(QDEPTH - 1)) ? '0 : tail_reg + QAW'(1);
        end
        if (cmd_take)
        begin
            head_next = (head_reg == QAW'(QDEPTH - 1)) ? '0 : head_reg + QAW'(1);
        end
        if (push && !cmd_take)
        begin
            cnt_next = cnt_reg + QCW'(1);
        end
        else if (!push && cmd_take)
        begin
            cnt_next = cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[tail_reg] <= cmd_in;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCW'(QDEPTH))
        else $error("command queue count beyond its depth");

    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("command taken from an empty queue");

endmodule

// ===== design/orbc_back.sv =====
module orbc_back #(
    parameter int DEPTH = orbc_pkg::DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [orbc_pkg::CAP_W-1:0]      capacity,
    input  logic                            cmd_valid,
    input  orbc_pkg::cmd_t                  cmd,
    output logic                            cmd_take,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [orbc_pkg::WORD_W-1:0]     data_out,
    output logic                            status,
    output logic [orbc_pkg::OCC_W-1:0]      occupancy,
    output logic [orbc_pkg::OVW_W-1:0]      overwrites,
    output logic [orbc_pkg::CKS_W-1:0]      checksum,
    output logic                            last
);

    import orbc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = CW + 1;
    localparam int CAP_RST_I = (int'(CAP_RESET) > DEPTH) ? DEPTH :
                               ((int'(CAP_RESET) == 0) ? 1 : int'(CAP_RESET));
    localparam logic [CW-1:0]    CAP_RST = CW'(CAP_RST_I);
    localparam logic [OVW_W-1:0] OVW_MAX = '1;

    bk_state_t         state_reg, state_next;
    logic [CW-1:0]     cap_reg, cap_next;
    logic [PW-1:0]     wp_reg, wp_next;
    logic [PW-1:0]     rp_reg, rp_next;
    logic              wrap_reg, wrap_next;
    logic [OVW_W-1:0]  ovw_reg, ovw_next;
    logic [PW-1:0]     dpos_reg, dpos_next;
    logic [CW-1:0]     remain_reg, remain_next;
    logic [CKS_W-1:0]  sum_reg, sum_next;

    logic              out_valid_reg;
    logic [WORD_W-1:0] data_reg;
    logic              status_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic [OVW_W-1:0]  ovwo_reg;
    logic [CKS_W-1:0]  cks_reg;
    logic              last_reg;

    logic              load;
    logic [WORD_W-1:0] ld_data;
    logic              ld_status;
    logic [CKS_W-1:0]  ld_cks;
    logic              ld_last;

    logic              ram_we;
    logic              ram_re;
    logic [PW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [CW-1:0]     cap_eff;
    logic [CW-1:0]     occ_cur;
    logic [CW-1:0]     occ_new;
    logic              occ_zero;
    logic              full;
    logic              out_free;
    logic              remain_last;
    logic [EW-1:0]     wp_plus, rp_plus, dp_plus;
    logic              wp_at_end, rp_at_end, dp_at_end;
    logic [PW-1:0]     wp_inc, rp_inc, dp_inc;
    logic [CKS_W-1:0]  sum_new;

    // Capacity zero behaves as one; anything above the built depth is clipped.
    always_comb
    begin
        if (capacity == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (int'(capacity) > DEPTH)
        begin
            cap_eff = CW'(DEPTH);
        end
        else
        begin
            cap_eff = CW'(capacity);
        end
    end

    assign wp_plus   = EW'(wp_reg) + EW'(1);
    assign rp_plus   = EW'(rp_reg) + EW'(1);
    assign dp_plus   = EW'(dpos_reg) + EW'(1);
    assign wp_at_end = (wp_plus >= EW'(cap_reg));
    assign rp_at_end = (rp_plus >= EW'(cap_reg));
    assign dp_at_end = (dp_plus >= EW'(cap_reg));
    assign wp_inc    = wp_at_end ? '0 : wp_plus[PW-1:0];
    assign rp_inc    = rp_at_end ? '0 : rp_plus[PW-1:0];
    assign dp_inc    = dp_at_end ? '0 : dp_plus[PW-1:0];

    assign occ_cur     = (wrap_reg ? cap_reg : '0) + CW'(wp_reg) - CW'(rp_reg);
    assign occ_new     = (wrap_next ? cap_next : '0) + CW'(wp_next) - CW'(rp_next);
    assign occ_zero    = (occ_cur == '0);
    assign full        = wrap_reg && (wp_reg == rp_reg);
    assign out_free    = !out_valid_reg || !out_stall;
    assign remain_last = (remain_reg == CW'(1));
    assign sum_new     = sum_reg + byte_sum(ram_rdata);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cfg_we && cmd_valid && out_free && !occ_zero)
                begin
                    if (cmd.op == OP_POP)
                    begin
                        state_next = ST_POP_WAIT;
                    end
                    else if (cmd.op == OP_DUMP)
                    begin
                        state_next = ST_DUMP;
                    end
                end
            end
            ST_POP_WAIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                if (out_free && remain_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cap_next    = cap_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        wrap_next   = wrap_reg;
        ovw_next    = ovw_reg;
        dpos_next   = dpos_reg;
        remain_next = remain_reg;
        sum_next    = sum_reg;
        cmd_take    = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = rp_reg;
        load        = 1'b0;
        ld_data     = '0;
        ld_status   = 1'b0;
        ld_cks      = '0;
        ld_last     = 1'b1;

        if (cfg_we)
        begin
            cap_next  = cap_eff;
            wp_next   = '0;
            rp_next   = '0;
            wrap_next = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid && out_free)
                    begin
                        cmd_take = 1'b1;
                        unique case (cmd.op)
                            OP_PUT:
                            begin
                                // A full ring drops its oldest word first.
                                if (full)
                                begin
                                    rp_next = rp_inc;
                                    if (rp_at_end)
                                    begin
                                        wrap_next = 1'b0;
                                    end
                                    if (ovw_reg != OVW_MAX)
                                    begin
                                        ovw_next = ovw_reg + OVW_W'(1);
                                    end
                                end
                                if (wp_at_end)
                                begin
                                    wrap_next = 1'b1;
                                end
                                ram_we  = 1'b1;
                                wp_next = wp_inc;
                                load    = 1'b1;
                            end
                            OP_POP:
                            begin
                                if (occ_zero)
                                begin
                                    load      = 1'b1;
                                    ld_data   = EMPTY_WORD;
                                    ld_status = 1'b1;
                                end
                                else
                                begin
                                    ram_re  = 1'b1;
                                    rp_next = rp_inc;
                                    if (rp_at_end)
                                    begin
                                        wrap_next = 1'b0;
                                    end
                                end
                            end
                            OP_DUMP:
                            begin
                                if (occ_zero)
                                begin
                                    load      = 1'b1;
                                    ld_data   = EMPTY_WORD;
                                    ld_status = 1'b1;
                                end
                                else
                                begin
                                    ram_re      = 1'b1;
                                    dpos_next   = rp_inc;
                                    remain_next = occ_cur;
                                    sum_next    = '0;
                                end
                            end
                            OP_CLEAR:
                            begin
                                wp_next   = '0;
                                rp_next   = '0;
                                wrap_next = 1'b0;
                                load      = 1'b1;
                            end
                            default:
                            begin
                                load = 1'b0;
                            end
                        endcase
                    end
                end
                ST_POP_WAIT:
                begin
                    if (out_free)
                    begin
                        load    = 1'b1;
                        ld_data = ram_rdata;
                    end
                end
                ST_DUMP:
                begin
                    // One stored word per transfer; the next read is issued as
                    // the current word moves into the output register.
                    if (out_free)
                    begin
                        load    = 1'b1;
                        ld_data = ram_rdata;
                        if (remain_last)
                        begin
                            ld_cks = sum_new;
                        end
                        else
                        begin
                            ld_last     = 1'b0;
                            ram_re      = 1'b1;
                            ram_raddr   = dpos_reg;
                            dpos_next   = dp_inc;
                            remain_next = remain_reg - CW'(1);
                            sum_next    = sum_new;
                        end
                    end
                end
                default:
                begin
                    load = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RST;
            wp_reg        <= '0;
            rp_reg        <= '0;
            wrap_reg      <= 1'b0;
            ovw_reg       <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cap_reg    <= cap_next;
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            wrap_reg   <= wrap_next;
            ovw_reg    <= ovw_next;
            remain_reg <= remain_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dpos_reg <= dpos_next;
        sum_reg  <= sum_next;
        if (load)
        begin
            data_reg   <= ld_data;
            status_reg <= ld_status;
            occ_reg    <= OCC_W'(occ_new);
            ovwo_reg   <= ovw_next;
            cks_reg    <= ld_cks;
            last_reg   <= ld_last;
        end
    end

    orbc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (cmd.data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign data_out   = data_reg;
    assign status     = status_reg;
    assign occupancy  = occ_reg;
    assign overwrites = ovwo_reg;
    assign checksum   = cks_reg;
    assign last       = last_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(wp_reg) < cap_reg) && (CW'(rp_reg) < cap_reg))
        else $error("ring position outside the capacity");

    a_wrap_order: assert property (@(posedge clk) disable iff (!rst_n)
        wrap_reg ? (wp_reg <= rp_reg) : (wp_reg >= rp_reg))
        else $error("write position passed the read position");

    a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> (remain_reg != '0))
        else $error("dump walking with no words left");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (last_reg && (data_reg == EMPTY_WORD)))
        else $error("empty status on a result that is not a final sentinel");

endmodule

// ===== design/overwriting_ring_buffer_checksum_core.sv =====
// Results: put, clear and an empty pop or dump pass through the command queue and the output register;
// a pop with data, and each word of a dump, also pass through the RAM's registered read port.
// The single back-end sequencer takes a new command only while idle: a pop with data waits in
// ST_POP_WAIT and a dump walks ST_DUMP once per stored word, and output stalls hold either.
// Reset (rst_n low, asynchronous) empties the ring and queue, clears the overwrite count and
// sets capacity to 32 clipped to DEPTH; stored words are undefined until written.
module overwriting_ring_buffer_checksum_core #(
    parameter int DEPTH = orbc_pkg::DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [orbc_pkg::CAP_W-1:0]      capacity,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [orbc_pkg::OP_W-1:0]       op,
    input  logic [orbc_pkg::WORD_W-1:0]     data_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [orbc_pkg::WORD_W-1:0]     data_out,
    output logic                            status,
    output logic [orbc_pkg::OCC_W-1:0]      occupancy,
    output logic [orbc_pkg::OVW_W-1:0]      overwrites,
    output logic [orbc_pkg::CKS_W-1:0]      checksum,
    output logic                            last
);

    import orbc_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_take;

    orbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .data_in   (data_in),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    orbc_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .capacity   (capacity),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_out   (data_out),
        .status     (status),
        .occupancy  (occupancy),
        .overwrites (overwrites),
        .checksum   (checksum),
        .last       (last)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import orbc_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int AW         = $clog2(DEPTH);
    localparam int HOLD_LEN   = 300;
    localparam int SETTLE     = 4;
    localparam int SAT_PUTS   = 6;
    localparam int PHASES     = 9;

    typedef struct packed {
        logic [WORD_W-1:0] data;
        logic              status;
        logic [OCC_W-1:0]  occ;
        logic [OVW_W-1:0]  ovw;
        logic [CKS_W-1:0]  cks;
        logic              last;
    } ring_result_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CAP_W-1:0]   capacity = CAP_RESET;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [OP_W-1:0]    op = OP_PUT;
    logic [WORD_W-1:0]  data_in = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [WORD_W-1:0]  data_out;
    logic               status;
    logic [OCC_W-1:0]   occupancy;
    logic [OVW_W-1:0]   overwrites;
    logic [CKS_W-1:0]   checksum;
    logic               last;

    cmd_t         pending_cmds[$];
    ring_result_t expected_results[$];
    int           mismatch_count = 0;
    logic         in_taken = 1'b0;
    logic         idle_off = 1'b0;
    logic         hold_req = 1'b0;
    logic         hold_done = 1'b0;
    int           send_idle_left = 0;
    int           recv_idle_left = 0;
    int           hold_left = 0;

    // Shadow copy of the ring.
    logic [WORD_W-1:0] ring_words [DEPTH];
    logic [CAP_W-1:0]  wr_pos;
    logic [CAP_W-1:0]  rd_pos;
    logic [CAP_W-1:0]  cap_reg;
    logic              lapped;
    logic [OVW_W-1:0]  lost_count;

    overwriting_ring_buffer_checksum_core #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .capacity   (capacity),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .data_in    (data_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_out   (data_out),
        .status     (status),
        .occupancy  (occupancy),
        .overwrites (overwrites),
        .checksum   (checksum),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [CAP_W-1:0] active_cap();
        if (cap_reg == '0)
            return CAP_W'(1);
        if (cap_reg > DEPTH)
            return CAP_W'(DEPTH);
        return cap_reg;
    endfunction

    function automatic logic [OCC_W-1:0] words_held();
        return (lapped ? active_cap() : CAP_W'(0)) + wr_pos - rd_pos;
    endfunction

    task automatic push_result(logic [WORD_W-1:0] d, logic st, logic [CKS_W-1:0] ck, logic fin);
        ring_result_t r;
        r.data   = d;
        r.status = st;
        r.occ    = words_held();
        r.ovw    = lost_count;
        r.cks    = ck;
        r.last   = fin;
        expected_results.push_back(r);
    endtask

    task automatic advance_rd();
        rd_pos = rd_pos + CAP_W'(1);
        if (rd_pos >= active_cap())
        begin
            rd_pos = '0;
            lapped = 1'b0;
        end
    endtask

    task automatic ring_reset();
        foreach (ring_words[i])
            ring_words[i] = '0;
        wr_pos     = '0;
        rd_pos     = '0;
        lapped     = 1'b0;
        lost_count = '0;
        cap_reg    = CAP_RESET;
    endtask

    task automatic ring_config(logic [CAP_W-1:0] v);
        cap_reg = v;
        wr_pos  = '0;
        rd_pos  = '0;
        lapped  = 1'b0;
    endtask

    task automatic ring_step(op_t o, logic [WORD_W-1:0] d);
        logic [CAP_W-1:0]  cap;
        logic [OCC_W-1:0]  n;
        logic [CAP_W-1:0]  pos;
        logic [CKS_W-1:0]  sum;
        logic [WORD_W-1:0] w;
        cap = active_cap();
        case (o)
            OP_PUT:
            begin
                if (lapped && wr_pos == rd_pos)
                begin
                    advance_rd();
                    if (lost_count != '1)
                        lost_count = lost_count + OVW_W'(1);
                end
                ring_words[wr_pos[AW-1:0]] = d;
                wr_pos = wr_pos + CAP_W'(1);
                if (wr_pos >= cap)
                begin
                    wr_pos = '0;
                    lapped = 1'b1;
                end
                push_result('0, 1'b0, '0, 1'b1);
            end
            OP_POP:
            begin
                if (words_held() == '0)
                    push_result(EMPTY_WORD, 1'b1, '0, 1'b1);
                else
                begin
                    w = ring_words[rd_pos[AW-1:0]];
                    advance_rd();
                    push_result(w, 1'b0, '0, 1'b1);
                end
            end
            OP_DUMP:
            begin
                n   = words_held();
                pos = rd_pos;
                sum = '0;
                if (n == '0)
                    push_result(EMPTY_WORD, 1'b1, '0, 1'b1);
                for (int i = 0; i < n; i++)
                begin
                    w   = ring_words[pos[AW-1:0]];
                    sum = sum + w[7:0] + w[15:8] + w[23:16] + w[31:24];
                    if (i + 1 == n)
                        push_result(w, 1'b0, sum, 1'b1);
                    else
                        push_result(w, 1'b0, '0, 1'b0);
                    pos = pos + CAP_W'(1);
                    if (pos >= cap)
                        pos = '0;
                end
            end
            default:
            begin
                wr_pos = '0;
                rd_pos = '0;
                lapped = 1'b0;
                push_result('0, 1'b0, '0, 1'b1);
            end
        endcase
    endtask

    // Monitor: predict on every transfer in, and check every transfer out.
    always @(posedge clk)
    begin
        ring_result_t exp_r;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (cfg_we)
                ring_config(capacity);
            if (in_valid && !in_stall)
                ring_step(op_t'(op), data_in);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"unexpected result: data %h status %0d occ %0d ovw %0d ",
                                  "cks %h last %0d"},
                                 data_out, status, occupancy, overwrites, checksum, last);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (data_out !== exp_r.data || status !== exp_r.status ||
                        occupancy !== exp_r.occ || overwrites !== exp_r.ovw ||
                        checksum !== exp_r.cks || last !== exp_r.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display({"mismatch: expected data %h status %0d occ %0d ",
                                      "ovw %0d cks %h last %0d"},
                                     exp_r.data, exp_r.status, exp_r.occ, exp_r.ovw,
                                     exp_r.cks, exp_r.last);
                            $display({"          actual   data %h status %0d occ %0d ",
                                      "ovw %0d cks %h last %0d"},
                                     data_out, status, occupancy, overwrites, checksum, last);
                        end
                    end
                end
            end
        end
    end

    // Sender. A payload only changes once the previous one has been taken.
    always @(negedge clk)
    begin
        cmd_t c;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (send_idle_left > 0)
            begin
                in_valid <= 1'b0;
                send_idle_left--;
            end
            else if (pending_cmds.size() > 0 && !idle_off && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                send_idle_left = $urandom_range(1, 17) - 1;
            end
            else if (pending_cmds.size() > 0)
            begin
                c = pending_cmds.pop_front();
                in_valid <= 1'b1;
                op       <= c.op;
                data_in  <= c.data;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver, including the one long hold-off that backs the block up.
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (recv_idle_left > 0)
        begin
            out_stall <= 1'b1;
            recv_idle_left--;
        end
        else if (!idle_off && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            recv_idle_left = $urandom_range(1, 17) - 1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic add_cmd(op_t o, logic [WORD_W-1:0] d);
        cmd_t c;
        c.op   = o;
        c.data = d;
        pending_cmds.push_back(c);
    endtask

    task automatic add_random(int count, int put_pct);
        int r;
        int rest;
        logic [WORD_W-1:0] d;
        rest = 100 - put_pct;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 7))
                0:       d = '0;
                1:       d = '1;
                default: d = $urandom;
            endcase
            r = $urandom_range(0, 99);
            if (r < put_pct)
                add_cmd(OP_PUT, d);
            else if (r < put_pct + rest * 45 / 100)
                add_cmd(OP_POP, d);
            else if (r < put_pct + rest * 85 / 100)
                add_cmd(OP_DUMP, d);
            else
                add_cmd(OP_CLEAR, d);
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic change_capacity(logic [CAP_W-1:0] v);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        capacity <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin
        int phase_caps [PHASES];
        int phase_puts [PHASES];
        phase_caps = '{32, 1, 5, 63, 3, 17, 0, 32, 8};
        phase_puts = '{55, 40, 50, 70, 45, 60, 40, 65, 50};
        ring_reset();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty ring first, then a few words across the byte extremes.
        add_cmd(OP_POP, 32'h1234_5678);
        add_cmd(OP_DUMP, '0);
        add_cmd(OP_CLEAR, '1);
        add_cmd(OP_PUT, 32'h0000_0000);
        add_cmd(OP_PUT, 32'hFFFF_FFFF);
        add_cmd(OP_PUT, 32'h8000_0001);
        add_cmd(OP_DUMP, '0);
        add_cmd(OP_POP, '0);
        add_cmd(OP_POP, '0);
        add_cmd(OP_POP, '0);
        add_cmd(OP_POP, '0);

        // Two entries: overwrite of the oldest word, then clear.
        change_capacity(6'd2);
        add_cmd(OP_PUT, 32'h1111_1111);
        add_cmd(OP_PUT, 32'h2222_2222);
        add_cmd(OP_PUT, 32'h3333_3333);
        add_cmd(OP_DUMP, '0);
        add_cmd(OP_POP, '0);
        add_cmd(OP_PUT, 32'h4444_4444);
        add_cmd(OP_CLEAR, '0);
        add_cmd(OP_DUMP, '0);
        add_cmd(OP_POP, '0);

        // A capacity of zero behaves as a single entry.
        change_capacity(6'd0);
        add_cmd(OP_PUT, 32'hA5A5_A5A5);
        add_cmd(OP_PUT, 32'h5A5A_5A5A);
        add_cmd(OP_DUMP, '0);
        add_cmd(OP_POP, '0);
        add_cmd(OP_DUMP, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            change_capacity(CAP_W'(phase_caps[p]));
            if (p == 3)
                hold_req = 1'b1;
            add_random(32, phase_puts[p]);
        end

        // Closing stretch runs at full rate with overwrites on a single entry.
        change_capacity(6'd1);
        idle_off = 1'b1;
        for (int i = 0; i < SAT_PUTS; i++)
            add_cmd(OP_PUT, $urandom);
        add_cmd(OP_DUMP, '0);
        add_cmd(OP_PUT, 32'hDEAD_BEEF);
        add_cmd(OP_POP, '0);
        add_cmd(OP_POP, '0);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/orbc_pkg.sv
design/orbc_ram.sv
design/orbc_front.sv
design/orbc_back.sv
design/overwriting_ring_buffer_checksum_core.sv
test/testbench.sv
